FILE: rtl/core/cda_pkg.sv
// Shared types, constants and the month-length table for the calendar date adder.
// No dependencies; every other file of the block uses this package.
package cda_pkg;

    localparam int YEAR_BITS_DEFAULT = 14;

    // Payload widths of the input and result items.
    localparam int OP_W        = 2;
    localparam int SET_YEAR_W  = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int AMOUNT_W    = 16;
    localparam int DATE_YEAR_W = 14;

    // The working day holds a full day of month plus the largest amount.
    localparam int WDAY_W = 17;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int LEAP_CYCLE      = 400;
    localparam int CENTURY         = 100;
    localparam int LEAP_EVERY      = 4;
    localparam int FEB_DAYS        = 28;
    localparam int LONG_MONTH_DAYS = 31;
    localparam int FEBRUARY        = 2;

    localparam int RESET_YEAR  = 2000;
    localparam int RESET_MONTH = 1;
    localparam int RESET_DAY   = 1;

    // The remainder register of the divider must hold any value below 400.
    localparam int REM_W = $clog2(LEAP_CYCLE);

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 2'd0,
        OP_ADD_DAYS   = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_YEARS  = 2'd3
    } t_op;

    typedef enum logic {
        DIV_BY_12  = 1'b0,
        DIV_BY_400 = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     start;
        t_div_sel sel;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_div_rsp;

    // Length of a month in a common year; codes outside 1..12 have no days.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                   len = DAY_W'(FEB_DAYS);
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(LONG_MONTH_DAYS - 1);
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:     len = DAY_W'(LONG_MONTH_DAYS);
            default:                len = '0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/cda_in_if.sv
// Input channel of the calendar date adder: valid/ready plus one operation item.
// Depends on cda_pkg for the field widths.
interface cda_in_if;
    logic                            valid;
    logic                            ready;
    logic [cda_pkg::OP_W-1:0]        operation;
    logic [cda_pkg::SET_YEAR_W-1:0]  set_year;
    logic [cda_pkg::MONTH_W-1:0]     set_month;
    logic [cda_pkg::DAY_W-1:0]       set_day;
    logic [cda_pkg::AMOUNT_W-1:0]    amount;

    modport source (
        output valid, operation, set_year, set_month, set_day, amount,
        input  ready
    );
    modport sink (
        input  valid, operation, set_year, set_month, set_day, amount,
        output ready
    );
endinterface

FILE: rtl/core/cda_out_if.sv
// Result channel of the calendar date adder: valid/ready plus the current date.
// Depends on cda_pkg for the field widths.
interface cda_out_if;
    logic                             valid;
    logic                             ready;
    logic [cda_pkg::DATE_YEAR_W-1:0]  date_year;
    logic [cda_pkg::MONTH_W-1:0]      date_month;
    logic [cda_pkg::DAY_W-1:0]        date_day;
    logic                             year_overflow;

    modport source (
        output valid, date_year, date_month, date_day, year_overflow,
        input  ready
    );
    modport sink (
        input  valid, date_year, date_month, date_day, year_overflow,
        output ready
    );
endinterface

FILE: rtl/core/cda_div.sv
// Shared divider by 12 or 400 built on one reciprocal multiplier; it holds one request at a time.
// Depends on cda_pkg for the request and response structs.
module cda_div #(
    parameter int W = cda_pkg::WDAY_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cda_pkg::t_div_req i_req,
    input  logic [W-1:0]      i_dividend,
    output cda_pkg::t_div_rsp o_rsp,
    output logic [W-1:0]      o_quotient
);
    import cda_pkg::*;

    // With L = ceil(log2 d) and M = ceil(2^(W+L) / d), (x * M) >> (W+L) is the
    // exact quotient for every W-bit x.
    localparam int L12    = $clog2(MONTHS_PER_YEAR);
    localparam int L400   = $clog2(LEAP_CYCLE);
    localparam int MUL_W  = W + 2;
    localparam int PROD_W = W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP_12 =
        MUL_W'(((64'd1 << (W + L12)) + 64'(MONTHS_PER_YEAR - 1)) / 64'(MONTHS_PER_YEAR));
    localparam logic [MUL_W-1:0] RECIP_400 =
        MUL_W'(((64'd1 << (W + L400)) + 64'(LEAP_CYCLE - 1)) / 64'(LEAP_CYCLE));

    logic             r_quo_pend;
    logic             r_rem_pend;
    logic             r_done;
    t_div_sel         r_sel;
    logic [W-1:0]     r_x;
    logic [W-1:0]     r_quo;
    logic [REM_W-1:0] r_rem;

    logic [MUL_W-1:0]  recip;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quo_12;
    logic [PROD_W-1:0] quo_400;
    logic [W-1:0]      quo;
    logic [W-1:0]      back;
    logic [W-1:0]      rem_full;

    assign recip   = (r_sel == DIV_BY_400) ? RECIP_400 : RECIP_12;
    assign prod    = {{MUL_W{1'b0}}, r_x} * {{W{1'b0}}, recip};
    assign quo_12  = prod >> (W + L12);
    assign quo_400 = prod >> (W + L400);
    assign quo     = (r_sel == DIV_BY_400) ? quo_400[W-1:0] : quo_12[W-1:0];

    // The remainder is formed from the registered quotient.
    assign back     = (r_sel == DIV_BY_400) ? W'(r_quo * W'(LEAP_CYCLE))
                                            : W'(r_quo * W'(MONTHS_PER_YEAR));
    assign rem_full = r_x - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo_pend <= 1'b0;
            r_rem_pend <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_quo_pend <= i_req.start;
            r_rem_pend <= r_quo_pend;
            r_done     <= r_rem_pend;
            if (i_req.start) begin
                r_x   <= i_dividend;
                r_sel <= i_req.sel;
            end
            if (r_quo_pend) begin
                r_quo <= quo;
            end
            if (r_rem_pend) begin
                r_rem <= rem_full[REM_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/calendar_date_adder_top.sv
// Calendar date adder top level: date registers, sequencer and result register.
// Depends on cda_pkg, cda_in_if, cda_out_if and cda_div.
//
// The block keeps a Gregorian date (reset value: 1 January 2000). Each item on
// i_in either loads a date, adds days, adds months or adds years; every item
// gives exactly one result item on o_out with the new date and a flag that is
// set when the year wrapped past its range during that item.
// One item is worked on at a time; i_in.ready is high only while the sequencer
// is idle. Set date and add years go straight to the result register; add months
// passes through the divider only when the month carries; add days passes through
// the divider and then walks month by month. The day walk subtracts one month
// length per cycle. The shared divider by 12 or 400 (a reciprocal multiply)
// finds the year modulo 400 at the start of a day walk and splits a month total
// into years and months. i_in.ready rises with o_out.valid.
// The result waits in an output register; while the receiver stalls, a
// finished item holds the sequencer and no new item is accepted.
// Reset is synchronous and active low and restores the reset date.
module calendar_date_adder_top #(
    parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cda_in_if.sink    i_in,
    cda_out_if.source o_out
);
    import cda_pkg::*;

    localparam int DIV_W = (YEAR_BITS > WDAY_W) ? YEAR_BITS : WDAY_W;
    localparam int ADD_W = DIV_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_DONE
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic [YEAR_BITS-1:0]   r_year;
    logic [MONTH_W-1:0]     r_month;
    logic [WDAY_W-1:0]      r_wday;
    logic [REM_W-1:0]       r_y400;
    logic                   r_wrap;
    logic                   r_out_valid;
    logic [DATE_YEAR_W-1:0] r_out_year;
    logic [MONTH_W-1:0]     r_out_month;
    logic [DAY_W-1:0]       r_out_day;
    logic                   r_out_ovf;

    t_op                              in_op;
    logic                             accept;
    logic [WDAY_W-1:0]                mon_total;
    logic                             mon_carry;
    logic [ADD_W-1:0]                 year_wide;
    logic [ADD_W-1:0]                 mon_wide;
    logic [ADD_W-1:0]                 addend;
    logic [ADD_W-1:0]                 year_sum;
    logic [YEAR_BITS-1:0]             year_next;
    logic                             year_ovf;
    logic [YEAR_BITS+SET_YEAR_W-1:0]  set_wide;
    logic [YEAR_BITS+DATE_YEAR_W-1:0] out_wide;
    logic                             leap;
    logic [DAY_W-1:0]                 mlen;
    logic                             walk_more;
    logic                             month_wraps;
    logic [MONTH_W-1:0]               month_step;
    t_div_req                         div_req;
    t_div_rsp                         div_rsp;
    logic [DIV_W-1:0]                 div_dividend;
    logic [DIV_W-1:0]                 div_quotient;

    assign in_op      = t_op'(i_in.operation);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign mon_total = {{(WDAY_W - MONTH_W){1'b0}}, r_month}
                     + {{(WDAY_W - AMOUNT_W){1'b0}}, i_in.amount};
    assign mon_carry = mon_total > WDAY_W'(MONTHS_PER_YEAR);

    assign year_wide = {{(ADD_W - YEAR_BITS){1'b0}}, r_year};
    assign mon_wide  = {{(ADD_W - WDAY_W){1'b0}}, mon_total - WDAY_W'(1)};
    assign set_wide  = {{YEAR_BITS{1'b0}}, i_in.set_year};
    assign out_wide  = {{DATE_YEAR_W{1'b0}}, r_year};

    // One year adder serves add years, the month carry and the day walk.
    always_comb begin
        unique case (r_state)
            S_IDLE:  addend = {{(ADD_W - AMOUNT_W){1'b0}}, i_in.amount};
            S_DIV:   addend = {1'b0, div_quotient};
            default: addend = ADD_W'(1);
        endcase
    end

    assign year_sum  = year_wide + addend;
    assign year_next = year_sum[YEAR_BITS-1:0];
    assign year_ovf  = |year_sum[ADD_W-1:YEAR_BITS];

    // Since 4 and 100 divide 400, the year modulo 400 settles the leap rules.
    assign leap = (r_y400[1:0] == 2'(LEAP_EVERY))
               && (r_y400 != REM_W'(CENTURY))
               && (r_y400 != REM_W'(2 * CENTURY))
               && (r_y400 != REM_W'(3 * CENTURY));

    assign mlen = month_len(r_month)
                + DAY_W'((r_month == MONTH_W'(FEBRUARY)) && leap);
    assign walk_more   = r_wday > {{(WDAY_W - DAY_W){1'b0}}, mlen};
    assign month_wraps = r_month >= MONTH_W'(MONTHS_PER_YEAR);
    assign month_step  = month_wraps ? r_month - MONTH_W'(MONTHS_PER_YEAR - 1)
                                     : r_month + MONTH_W'(1);

    assign div_req.start = accept
                        && ((in_op == OP_ADD_DAYS) || ((in_op == OP_ADD_MONTHS) && mon_carry));
    assign div_req.sel   = (in_op == OP_ADD_DAYS) ? DIV_BY_400 : DIV_BY_12;
    assign div_dividend  = (in_op == OP_ADD_DAYS) ? year_wide[DIV_W-1:0]
                                                  : mon_wide[DIV_W-1:0];

    cda_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .o_rsp      (div_rsp),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SET;
            r_year      <= YEAR_BITS'(RESET_YEAR);
            r_month     <= MONTH_W'(RESET_MONTH);
            r_wday      <= WDAY_W'(RESET_DAY);
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the result register is reloaded, which also retires a taken result.
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= in_op;
                        r_wrap <= 1'b0;
                        unique case (in_op)
                            OP_SET: begin
                                r_year  <= set_wide[YEAR_BITS-1:0];
                                r_month <= i_in.set_month;
                                r_wday  <= {{(WDAY_W - DAY_W){1'b0}}, i_in.set_day};
                                r_state <= S_DONE;
                            end
                            OP_ADD_DAYS: begin
                                r_wday  <= r_wday + {{(WDAY_W - AMOUNT_W){1'b0}}, i_in.amount};
                                r_state <= S_DIV;
                            end
                            OP_ADD_MONTHS: begin
                                if (mon_carry) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_month <= mon_total[MONTH_W-1:0];
                                    r_state <= S_DONE;
                                end
                            end
                            OP_ADD_YEARS: begin
                                r_year  <= year_next;
                                r_wrap  <= year_ovf;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_op == OP_ADD_DAYS) begin
                            r_y400  <= div_rsp.rem;
                            r_state <= S_WALK;
                        end else begin
                            r_year  <= year_next;
                            r_wrap  <= year_ovf;
                            r_month <= div_rsp.rem[MONTH_W-1:0] + MONTH_W'(1);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_more) begin
                        r_wday  <= r_wday - {{(WDAY_W - DAY_W){1'b0}}, mlen};
                        r_month <= month_step;
                        if (month_wraps) begin
                            r_year <= year_next;
                            // A wrapped year restarts at zero, which is also 0 mod 400.
                            if (year_ovf || (r_y400 == REM_W'(LEAP_CYCLE - 1))) begin
                                r_y400 <= '0;
                            end else begin
                                r_y400 <= r_y400 + REM_W'(1);
                            end
                            if (year_ovf) begin
                                r_wrap <= 1'b1;
                            end
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_year  <= out_wide[DATE_YEAR_W-1:0];
                        r_out_month <= r_month;
                        r_out_day   <= r_wday[DAY_W-1:0];
                        r_out_ovf   <= r_wrap;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.date_year     = r_out_year;
    assign o_out.date_month    = r_out_month;
    assign o_out.date_day      = r_out_day;
    assign o_out.year_overflow = r_out_ovf;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for calendar_date_adder_top: random and directed date operations.
// Depends on cda_pkg, cda_in_if, cda_out_if and the RTL of the block; it keeps its own
// calendar predictor and checks every result item against it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cda_pkg::*;

    localparam int YEAR_BITS = YEAR_BITS_DEFAULT;
    localparam int unsigned YEAR_MASK = (1 << YEAR_BITS) - 1;
    localparam int unsigned OUTPUT_HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 2400;

    typedef struct packed {
        logic [DATE_YEAR_W-1:0] year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic                   overflow;
    } t_date;

    logic clk = 1'b0;
    logic rst_n;

    cda_in_if  in_ch ();
    cda_out_if out_ch ();

    calendar_date_adder_top #(.YEAR_BITS(YEAR_BITS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Predicted calendar state and the dates still owed by the block.
    int unsigned cal_year  = RESET_YEAR;
    int unsigned cal_month = RESET_MONTH;
    int unsigned cal_wday  = RESET_DAY;
    t_date       pending_dates[$];

    int unsigned mismatch_count = 0;
    bit          idle_off = 1'b0;
    int unsigned results_hold_cycles = 0;

    function automatic int unsigned draw_wait();
        if (idle_off) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
        int unsigned days;
        case (mo)
            2:                      days = 28;
            4, 6, 9, 11:            days = 30;
            1, 3, 5, 7, 8, 10, 12:  days = 31;
            default:                days = 0;
        endcase
        if (mo == FEBRUARY && yr % LEAP_EVERY == 0 &&
                (yr % CENTURY != 0 || yr % LEAP_CYCLE == 0)) begin
            days++;
        end
        return days;
    endfunction

    function automatic bit advance_year(input int unsigned inc);
        int unsigned sum;
        sum = cal_year + inc;
        cal_year = sum & YEAR_MASK;
        return sum > YEAR_MASK;
    endfunction

    function automatic bit advance_month(input int unsigned inc);
        int unsigned total;
        bit          wrapped;
        total = cal_month + inc;
        wrapped = 1'b0;
        if (total > MONTHS_PER_YEAR) begin
            wrapped = advance_year((total - 1) / MONTHS_PER_YEAR);
            total = (total - 1) % MONTHS_PER_YEAR + 1;
        end
        cal_month = total;
        return wrapped;
    endfunction

    function automatic t_date apply_date_op(input t_op op, input logic [SET_YEAR_W-1:0] sy,
                                            input logic [MONTH_W-1:0] sm,
                                            input logic [DAY_W-1:0] sd,
                                            input logic [AMOUNT_W-1:0] amt);
        t_date       res;
        bit          wrapped;
        int unsigned len;
        wrapped = 1'b0;
        case (op)
            OP_SET: begin
                cal_year = sy & YEAR_MASK;
                cal_month = sm;
                cal_wday = sd;
            end
            OP_ADD_DAYS: begin
                // One month per pass; a day past the month end is reduced even for zero days.
                len = month_days(cal_year, cal_month);
                cal_wday += amt;
                while (cal_wday > len) begin
                    cal_wday -= len;
                    if (advance_month(1)) wrapped = 1'b1;
                    len = month_days(cal_year, cal_month);
                end
            end
            OP_ADD_MONTHS: wrapped = advance_month(amt);
            default:       wrapped = advance_year(amt);
        endcase
        res.year = DATE_YEAR_W'(cal_year);
        res.month = MONTH_W'(cal_month);
        res.day = DAY_W'(cal_wday);
        res.overflow = wrapped;
        return res;
    endfunction

    task automatic send_item(input t_op op, input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned amt);
        int unsigned            gap;
        logic [SET_YEAR_W-1:0]  sy;
        logic [MONTH_W-1:0]     sm;
        logic [DAY_W-1:0]       sd;
        logic [AMOUNT_W-1:0]    sa;
        sy = SET_YEAR_W'(yr);
        sm = MONTH_W'(mo);
        sd = DAY_W'(dy);
        sa = AMOUNT_W'(amt);
        gap = draw_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.set_year  <= sy;
        in_ch.set_month <= sm;
        in_ch.set_day   <= sd;
        in_ch.amount    <= sa;
        do @(posedge clk); while (!in_ch.ready);
        pending_dates.push_back(apply_date_op(op, sy, sm, sd, sa));
    endtask

    // Lowers valid and waits until every owed result item has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_dates.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk) begin : check_results
        t_date want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result item with none expected, actual %0d-%0d-%0d", $time,
                         out_ch.date_year, out_ch.date_month, out_ch.date_day);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                if (out_ch.date_year !== want.year)
                    note_mismatch("date_year", want.year, out_ch.date_year);
                if (out_ch.date_month !== want.month)
                    note_mismatch("date_month", want.month, out_ch.date_month);
                if (out_ch.date_day !== want.day)
                    note_mismatch("date_day", want.day, out_ch.date_day);
                if (out_ch.year_overflow !== want.overflow)
                    note_mismatch("year_overflow", want.overflow, out_ch.year_overflow);
            end
        end
    end

    // Result receiver: random stalls per item, or a long hold-off when one is requested.
    initial begin : result_receiver
        int unsigned stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (results_hold_cycles > 0) begin
                stall = results_hold_cycles;
                results_hold_cycles = 0;
            end else begin
                stall = draw_wait();
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid && results_hold_cycles == 0);
        end
    end

    task automatic test_reset_date();
        send_item(OP_ADD_DAYS, 0, 0, 0, 0);
    endtask

    task automatic test_leap_rules();
        send_item(OP_SET, 2000, 2, 28, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 1);
        send_item(OP_ADD_DAYS, 0, 0, 0, 1);
        send_item(OP_SET, 1900, 2, 28, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 1);
        // A leap day carried into a common year is kept until days are added.
        send_item(OP_SET, 2024, 2, 29, 0);
        send_item(OP_ADD_YEARS, 0, 0, 0, 1);
        send_item(OP_ADD_DAYS, 0, 0, 0, 0);
    endtask

    task automatic test_month_carry();
        send_item(OP_SET, 2010, 1, 31, 0);
        send_item(OP_ADD_MONTHS, 0, 0, 0, 23);
        send_item(OP_ADD_MONTHS, 0, 0, 0, 65535);
        send_item(OP_SET, 5, 13, 10, 0);
        send_item(OP_ADD_MONTHS, 0, 0, 0, 0);
    endtask

    task automatic test_odd_month_codes();
        send_item(OP_SET, 7, 0, 5, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 0);
        send_item(OP_SET, 0, 0, 0, 0);
        send_item(OP_ADD_MONTHS, 0, 0, 0, 0);
        send_item(OP_SET, 16383, 15, 31, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 0);
    endtask

    task automatic test_year_wrap();
        send_item(OP_SET, 16383, 12, 31, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 1);
        send_item(OP_SET, 16383, 7, 4, 0);
        send_item(OP_ADD_YEARS, 0, 0, 0, 65535);
    endtask

    task automatic test_largest_step();
        send_item(OP_SET, 0, 1, 1, 0);
        send_item(OP_ADD_DAYS, 0, 0, 0, 65535);
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned pick, yr, mo, dy, amt;
        t_op         op;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 20) ? OP_SET : (pick < 60) ? OP_ADD_DAYS :
                 (pick < 80) ? OP_ADD_MONTHS : OP_ADD_YEARS;
            pick = $urandom_range(0, 7);
            if (pick == 0)      yr = 100 * $urandom_range(0, 163);
            else if (pick == 1) yr = 16383 - $urandom_range(0, 3);
            else                yr = $urandom_range(0, 16383);
            if ($urandom_range(0, 9) == 0) begin
                pick = $urandom_range(0, 3);
                mo = (pick == 0) ? 0 : 12 + pick;
            end else begin
                mo = $urandom_range(1, 12);
            end
            // Mostly real dates; now and then a day that the month cannot hold.
            if (month_days(yr, mo) == 0 || $urandom_range(0, 9) == 0)
                dy = $urandom_range(0, 31);
            else
                dy = $urandom_range(1, month_days(yr, mo));
            pick = $urandom_range(0, 19);
            if (pick < 8)       amt = $urandom_range(0, 40);
            else if (pick < 14) amt = $urandom_range(0, 400);
            else if (pick < 17) amt = $urandom_range(0, 5000);
            else                amt = $urandom_range(0, 65535);
            send_item(op, yr, mo, dy, amt);
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block stalls its input.
    task automatic test_output_backpressure();
        wait_drained();
        results_hold_cycles = OUTPUT_HOLD_CYCLES;
        idle_off = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_item((i % 2 == 0) ? OP_ADD_DAYS : OP_ADD_MONTHS, 0, 0, 0,
                      $urandom_range(0, 60));
        end
        idle_off = 1'b0;
        wait_drained();
    endtask

    initial begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_SET;
        in_ch.set_year  <= '0;
        in_ch.set_month <= '0;
        in_ch.set_day   <= '0;
        in_ch.amount    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_date();
        test_leap_rules();
        test_month_carry();
        test_odd_month_codes();
        test_year_wrap();
        test_largest_step();
        test_random_traffic(80);
        wait_drained();
        idle_off = 1'b1;
        test_random_traffic(70);
        idle_off = 1'b0;
        test_output_backpressure();
        test_random_traffic(90);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
